[src/swaf_pkg.sv]
// Shared types and constants for the sliding window anagram finder.
// Holds command codes, queue sizing and the entry passed from the front part to the back part.
// No dependencies.
package swaf_pkg;

   localparam int MAX_PATTERN_DEF = 64;
   localparam int ALPHABET_DEF    = 26;
   localparam int LETTER_W        = 5;
   localparam int CMD_W           = 2;
   localparam int POS_W           = 32;

   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_PATTERN,
      OP_TEXT
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [LETTER_W-1:0]   code;
      logic                  remove;
      logic                  emit;
      logic [POS_W-1:0]      start_index;
      logic [LETTER_W-1:0]   oldest;
   } entry_type;

endpackage

[src/swaf_front.sv]
// Front part: accepts requests, keeps the window counters and the ring of recent text letters.
// Depends on swaf_pkg; feeds swaf_queue.
module swaf_front
   import swaf_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int ALPHABET    = ALPHABET_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [LETTER_W-1:0]   letter,
   input  logic [CMD_W-1:0]      cmd,
   input  logic [QCNT_W-1:0]     q_count,
   output logic                  push,
   output entry_type             push_entry
);

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int SUM_W = CNT_W + 1;

   logic [CNT_W-1:0]    plen_ff, plen_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [POS_W-1:0]    tpos_ff, tpos_in;
   logic                s1_valid_ff, s1_valid_in;
   entry_type           s1_ff, s1_in;
   logic [LETTER_W-1:0] oldest_ff;
   logic [LETTER_W-1:0] ring_mem [MAX_PATTERN];

   logic                accept;
   logic                letter_ok;
   logic                rem;
   logic                wr_en;
   logic                rd_en;
   logic [SUM_W-1:0]    sum;
   logic [PTR_W-1:0]    oldest_addr;
   logic [PTR_W-1:0]    ptr_step;
   logic [CNT_W-1:0]    fill_step;

   assign req_ready = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid_ff))
                      < (QCNT_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;
   assign letter_ok = int'(letter) < ALPHABET;

   assign rem       = fill_ff >= plen_ff;
   assign sum       = SUM_W'(ptr_ff) + SUM_W'(MAX_PATTERN) - SUM_W'(fill_ff);
   assign oldest_addr = (sum >= SUM_W'(MAX_PATTERN)) ? PTR_W'(sum - SUM_W'(MAX_PATTERN))
                                                     : PTR_W'(sum);
   assign ptr_step  = (ptr_ff == PTR_W'(MAX_PATTERN - 1)) ? '0 : ptr_ff + PTR_W'(1);
   assign fill_step = fill_ff - CNT_W'(rem) + CNT_W'(1);

   always_comb begin
      plen_in     = plen_ff;
      fill_in     = fill_ff;
      ptr_in      = ptr_ff;
      tpos_in     = tpos_ff;
      s1_valid_in = 1'b0;
      s1_in       = s1_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      s1_in.code        = letter;
      s1_in.remove      = 1'b0;
      s1_in.emit        = 1'b0;
      s1_in.oldest      = '0;
      s1_in.start_index = tpos_ff + POS_W'(1) - POS_W'(plen_ff);
      if (accept) begin
         unique case (cmd)
            CMD_CLEAR: begin
               plen_in     = '0;
               fill_in     = '0;
               ptr_in      = '0;
               tpos_in     = '0;
               s1_valid_in = 1'b1;
               s1_in.op    = OP_CLEAR;
            end
            CMD_PATTERN: begin
               if (letter_ok && (plen_ff < CNT_W'(MAX_PATTERN))) begin
                  plen_in     = plen_ff + CNT_W'(1);
                  s1_valid_in = 1'b1;
                  s1_in.op    = OP_PATTERN;
               end
            end
            CMD_TEXT: begin
               if (letter_ok) begin
                  tpos_in = tpos_ff + POS_W'(1);
                  if (plen_ff != '0) begin
                     wr_en        = 1'b1;
                     rd_en        = rem;
                     ptr_in       = ptr_step;
                     fill_in      = fill_step;
                     s1_valid_in  = 1'b1;
                     s1_in.op     = OP_TEXT;
                     s1_in.remove = rem;
                     s1_in.emit   = fill_step >= plen_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff     <= '0;
         fill_ff     <= '0;
         ptr_ff      <= '0;
         tpos_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         plen_ff     <= plen_in;
         fill_ff     <= fill_in;
         ptr_ff      <= ptr_in;
         tpos_ff     <= tpos_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_ff <= s1_in;
   end

   // Read-first ring: when the window spans the whole ring, the oldest slot is
   // the one being overwritten and the old letter is returned.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[ptr_ff] <= letter;
      end
      if (rd_en) begin
         oldest_ff <= ring_mem[oldest_addr];
      end
   end

   always_comb begin
      push_entry        = s1_ff;
      push_entry.oldest = oldest_ff;
   end
   assign push = s1_valid_ff;

   a_fill_in_window: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= plen_ff)
      else $error("window fill exceeds pattern length");

   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(MAX_PATTERN - 1))
      else $error("ring pointer outside ring");

endmodule

[src/swaf_queue.sv]
// Short in-order queue between the front part and the back part.
// Depends on swaf_pkg; instantiated by the top level.
module swaf_queue
   import swaf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  entry_type         push_entry,
   input  logic              pop,
   output logic              q_valid,
   output entry_type         head,
   output logic [QCNT_W-1:0] q_count
);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign q_valid = count_ff != '0;
   assign head    = slot_ff[rd_ptr_ff];
   assign q_count = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != QCNT_W'(QUEUE_DEPTH)))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");

endmodule

[src/swaf_back.sv]
// Back part: per-letter balance cells, match detection and the result register.
// Depends on swaf_pkg; drains swaf_queue.
module swaf_back
   import swaf_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int ALPHABET    = ALPHABET_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  entry_type         head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              is_match,
   output logic [POS_W-1:0]  start_index
);

   localparam int BAL_W = $clog2(MAX_PATTERN + 1) + 1;

   logic signed [BAL_W-1:0] bal_ff [ALPHABET];
   logic signed [BAL_W-1:0] bal_in [ALPHABET];
   logic [ALPHABET-1:0]     nz;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    match_ff;
   logic [POS_W-1:0]        start_ff;
   logic                    inc;
   logic                    dec;

   assign pop = q_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      for (int i = 0; i < ALPHABET; i++) begin
         inc = (head.op == OP_TEXT) && (int'(head.code) == i);
         dec = ((head.op == OP_TEXT) && head.remove && (int'(head.oldest) == i))
               || ((head.op == OP_PATTERN) && (int'(head.code) == i));
         if (head.op == OP_CLEAR) begin
            bal_in[i] = '0;
         end else begin
            bal_in[i] = bal_ff[i] + BAL_W'(inc) - BAL_W'(dec);
         end
         nz[i] = bal_in[i] != '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop && (head.op == OP_TEXT) && head.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ALPHABET; i++) begin
            bal_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            for (int i = 0; i < ALPHABET; i++) begin
               bal_ff[i] <= bal_in[i];
            end
         end
      end
      if (pop && (head.op == OP_TEXT) && head.emit) begin
         match_ff <= ~|nz;
         start_ff <= head.start_index;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign is_match    = match_ff;
   assign start_index = start_ff;

endmodule

[src/sliding_window_anagram_finder.sv]
// Top level of the sliding window anagram finder.
// Depends on swaf_pkg, swaf_front, swaf_queue and swaf_back.
//
// A clear request empties all state, pattern requests load letters (a to z as 0 to 25) and
// text requests slide a window of pattern length over the text; once the window is full each
// text letter returns one response with a match flag and the window's start index. The block
// takes one request per cycle; each request is registered in the front part and its result in
// the back part. The rate is set by the ring memory, which is written once and read once per
// text letter, and by the single update of the balance cells per item. Requests are accepted
// while a response waits, until the four-entry queue between the front and back parts fills.
module sliding_window_anagram_finder
   import swaf_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int ALPHABET    = ALPHABET_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] letter, [7:5] zero
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [0] is_match, [32:1] start_index, [39:33] zero
);

   logic               push;
   entry_type          push_entry;
   logic               pop;
   logic               q_valid;
   entry_type          head;
   logic [QCNT_W-1:0]  q_count;
   logic               is_match;
   logic [POS_W-1:0]   start_index;

   swaf_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .ALPHABET    (ALPHABET)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .letter     (req_tdata[LETTER_W-1:0]),
      .cmd        (req_tuser),
      .q_count    (q_count),
      .push       (push),
      .push_entry (push_entry)
   );

   swaf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_valid    (q_valid),
      .head       (head),
      .q_count    (q_count)
   );

   swaf_back #(
      .MAX_PATTERN (MAX_PATTERN),
      .ALPHABET    (ALPHABET)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .is_match    (is_match),
      .start_index (start_index)
   );

   assign rsp_tdata = {7'd0, start_index, is_match};

endmodule

[bench/sliding_window_anagram_finder_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the sliding window anagram finder, with its own window predictor.
// Depends on swaf_pkg and sliding_window_anagram_finder; reads no files.
module sliding_window_anagram_finder_test;
   import swaf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam int RANDOM_ITEMS = 1850;
   localparam int TIME_LIMIT   = 400000;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic [LETTER_W-1:0] letter;
   } request_type;

   typedef struct {
      logic             is_match;
      logic [POS_W-1:0] start_index;
   } window_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [4:0] letter, [7:5] zero
   logic [1:0]  req_tuser = 2'd0;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [0] is_match, [32:1] start_index, [39:33] zero

   request_type       request_queue[$];
   window_result_type expected_windows[$];
   request_type       next_request;
   window_result_type seen_window;

   int                  balance[ALPHABET_DEF];
   int                  nonzero_count;
   logic [LETTER_W-1:0] ring[MAX_PATTERN_DEF];
   int                  ring_ptr;
   int                  pat_len;
   int                  fill;
   logic [POS_W-1:0]    text_pos;

   int accepted = 0;
   int total_requests = 0;
   int effective_count = 0;
   int mismatches = 0;
   int cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int phase;
   int send_idle;
   int recv_idle;

   sliding_window_anagram_finder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   task automatic clear_window();
      for (int i = 0; i < ALPHABET_DEF; i++) balance[i] = 0;
      nonzero_count = 0;
      ring_ptr = 0;
      pat_len = 0;
      fill = 0;
      text_pos = '0;
   endtask

   task automatic shift_balance(input int code, input int delta);
      int was;
      was = balance[code];
      balance[code] = was + delta;
      if (was == 0 && balance[code] != 0) begin
         nonzero_count++;
      end else if (was != 0 && balance[code] == 0) begin
         nonzero_count--;
      end
   endtask

   task automatic predict_window(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] letter);
      window_result_type res;
      logic [POS_W-1:0] pos;
      if (cmd == CMD_CLEAR) begin
         clear_window();
         return;
      end
      if (cmd == CMD_UNKNOWN || letter >= ALPHABET_DEF) return;
      if (cmd == CMD_PATTERN) begin
         if (pat_len < MAX_PATTERN_DEF) begin
            pat_len++;
            shift_balance(letter, -1);
         end
         return;
      end
      pos = text_pos;
      text_pos = pos + 1;
      if (pat_len == 0) return;
      if (fill >= pat_len) begin
         shift_balance(ring[(ring_ptr + MAX_PATTERN_DEF - fill) % MAX_PATTERN_DEF], -1);
         fill--;
      end
      ring[ring_ptr] = letter;
      ring_ptr = (ring_ptr + 1) % MAX_PATTERN_DEF;
      fill++;
      shift_balance(letter, 1);
      if (fill < pat_len) return;
      res.is_match = (nonzero_count == 0);
      res.start_index = pos + 1 - pat_len;
      expected_windows = {expected_windows, res};
   endtask

   task automatic push_req(input logic [CMD_W-1:0] cmd, input int letter);
      request_type r;
      r.cmd = cmd;
      r.letter = LETTER_W'(letter);
      request_queue = {request_queue, r};
      if (!(cmd == CMD_UNKNOWN || (cmd != CMD_CLEAR && letter >= ALPHABET_DEF)))
         effective_count++;
   endtask

   task automatic push_ignored();
      if ($urandom_range(1) == 1) begin
         push_req(CMD_UNKNOWN, $urandom_range(0, 31));
      end else begin
         push_req($urandom_range(1) ? CMD_TEXT : CMD_PATTERN, $urandom_range(ALPHABET_DEF, 31));
      end
   endtask

   always_comb begin
      if (accepted < total_requests / 3) begin
         phase = 0;
         send_idle = 28;
         recv_idle = 83;
      end else if (accepted < 2 * total_requests / 3) begin
         phase = 1;
         send_idle = 83;
         recv_idle = 28;
      end else begin
         phase = 2;
         send_idle = 0;
         recv_idle = 0;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > TIME_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_window(req_tuser, req_tdata[LETTER_W-1:0]);
            accepted <= accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
               next_request = request_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {3'b000, next_request.letter};
               req_tuser <= next_request.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_windows.size() == 0) begin
               if (mismatches < 10)
                  $display("Unexpected request result: is_match %0d start_index %0d",
                           rsp_tdata[0], rsp_tdata[32:1]);
               mismatches++;
            end else begin
               seen_window = expected_windows.pop_front();
               if (rsp_tdata[0] !== seen_window.is_match
                   || rsp_tdata[32:1] !== seen_window.start_index) begin
                  if (mismatches < 10)
                     $display("Mismatch: is_match exp %0d got %0d, start_index exp %0d got %0d",
                              seen_window.is_match, rsp_tdata[0],
                              seen_window.start_index, rsp_tdata[32:1]);
                  mismatches++;
               end
            end
         end
         // The long hold-off lets the block fill up and stall its request side.
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (phase == 2 && !hold_done && total_requests != 0) begin
            rsp_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   initial begin
      int span;
      int base;
      int plen;
      int tlen;
      int r;
      clear_window();

      push_req(CMD_CLEAR, 0);
      push_req(CMD_TEXT, 0);
      push_req(CMD_TEXT, 25);
      push_req(CMD_PATTERN, 0);
      push_req(CMD_PATTERN, 25);
      push_req(CMD_PATTERN, 31);
      push_req(CMD_UNKNOWN, 5);
      push_req(CMD_TEXT, 26);
      push_req(CMD_TEXT, 25);
      push_req(CMD_TEXT, 0);
      push_req(CMD_TEXT, 0);
      push_req(CMD_TEXT, 25);
      push_req(CMD_PATTERN, 1);
      push_req(CMD_TEXT, 1);
      push_req(CMD_TEXT, 25);
      push_req(CMD_TEXT, 0);
      push_req(CMD_TEXT, 1);
      push_req(CMD_CLEAR, 31);
      push_req(CMD_PATTERN, 16);
      push_req(CMD_TEXT, 16);
      push_req(CMD_TEXT, 15);
      push_req(CMD_UNKNOWN, 31);
      push_req(CMD_TEXT, 16);

      effective_count = 0;
      while (effective_count < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 85) begin
            span = $urandom_range(1, 4);
            base = $urandom_range(0, ALPHABET_DEF - span);
            r = $urandom_range(99);
            if (r < 5) plen = $urandom_range(50, 70);
            else if (r < 8) plen = 0;
            else plen = $urandom_range(1, 8);
            push_req(CMD_CLEAR, $urandom_range(0, 31));
            repeat (plen) begin
               if ($urandom_range(99) < 5) push_ignored();
               push_req(CMD_PATTERN, base + $urandom_range(0, span - 1));
            end
            tlen = plen + $urandom_range(1, 20);
            repeat (tlen) begin
               r = $urandom_range(99);
               if (r < 4) begin
                  push_ignored();
               end else if (r < 6) begin
                  push_req(CMD_PATTERN, base + $urandom_range(0, span - 1));
               end
               push_req(CMD_TEXT, base + $urandom_range(0, span - 1));
            end
         end else begin
            push_req(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 31));
         end
      end
      total_requests = request_queue.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted != total_requests) @(posedge clock);
      while (expected_windows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_windows.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
